[src/wss_pkg.sv]
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types, register codes and helper functions of the wildcard
// signature scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    localparam int PATTERN_REGS = 4;
    localparam int PATTERN_BYTES = 32;
    localparam int DISP_BYTES = 4;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PATTERN_LOW      = 3'd0,
        CFG_PATTERN_MID_LOW  = 3'd1,
        CFG_PATTERN_MID_HIGH = 3'd2,
        CFG_PATTERN_HIGH     = 3'd3,
        CFG_WILDCARD_MASK    = 3'd4,
        CFG_PATTERN_LENGTH   = 3'd5,
        CFG_REF_MODE         = 3'd6,
        CFG_REF_OFFSET       = 3'd7
    } t_cfg_idx;

    // reference modes
    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_BRANCH = 2'd1,
        MODE_LOAD   = 2'd2
    } t_mode;

    localparam logic [1:0] BRANCH_DISP_AT = 2'd1;
    localparam logic [1:0] LOAD_DISP_AT   = 2'd3;
    localparam logic [2:0] BRANCH_LEN     = 3'd5;
    localparam logic [2:0] LOAD_LEN       = 3'd7;

    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] pattern;
        logic [PATTERN_BYTES-1:0]      wild;
        logic [5:0]                    len;
        logic [1:0]                    mode;
        logic [5:0]                    offset;
    } t_cfg;

    // one classified byte on its way from the front to the back
    typedef struct packed {
        logic [7:0]                 data;
        logic                       last;
        logic                       hit;
        logic [DISP_BYTES-1:0][7:0] cand;
        logic [2:0]                 cand_n;
        logic [1:0]                 mode;
        logic [5:0]                 offset;
        logic [5:0]                 len_m1;
    } t_item;

    function automatic logic uses_disp(input logic [1:0] mode);
        return (mode == MODE_BRANCH) || (mode == MODE_LOAD);
    endfunction

    function automatic logic [1:0] disp_at(input logic [1:0] mode);
        return (mode == MODE_BRANCH) ? BRANCH_DISP_AT : LOAD_DISP_AT;
    endfunction

    function automatic logic [2:0] instr_len(input logic [1:0] mode);
        return (mode == MODE_BRANCH) ? BRANCH_LEN : LOAD_LEN;
    endfunction

endpackage

`default_nettype wire

[src/wss_front.sv]
// ----------------------------------------------------------------------------
// wss_front
// Byte window and parallel wildcard compare. Tags each byte with its match
// result and the displacement bytes already sitting in the window.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_front #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire wss_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_data,
    input  wire logic           i_last,
    output logic                o_push,
    output wss_pkg::t_item      o_item,
    input  wire logic           i_full
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int WIN_IDX_W = $clog2(PATTERN_MAX);

    logic [PATTERN_MAX-1:0][7:0] r_win;
    logic [PATTERN_MAX-1:0][7:0] n_win;
    logic [PATTERN_MAX-1:0][7:0] base_win;
    logic [FILL_W-1:0]           r_fill;
    logic [FILL_W-1:0]           n_fill;
    logic [FILL_W-1:0]           base_fill;
    logic                        r_clr;
    logic                        r_fv;
    logic                        r_last;
    logic                        accept;

    logic [6:0]                  len_used;
    logic [5:0]                  len_m1;
    logic [PATTERN_MAX-1:0]      elem_ok;
    logic                        hit;
    logic [wss_pkg::DISP_BYTES-1:0]      avail;
    logic [wss_pkg::DISP_BYTES-1:0][7:0] cand;

    assign accept = i_valid && o_ready;
    assign o_ready = !r_fv || !i_full;
    assign o_push = r_fv && !i_full;

    // shift in the new byte; a stream that just ended starts from an empty window
    always_comb begin
        base_win = r_clr ? '0 : r_win;
        base_fill = r_clr ? '0 : r_fill;
        n_win = {base_win[PATTERN_MAX-2:0], i_data};
        n_fill = (base_fill < FILL_W'(PATTERN_MAX)) ? base_fill + FILL_W'(1) : base_fill;
    end

    always_comb begin
        if (i_cfg.len == 6'd0) begin
            len_used = 7'd1;
        end else if ({1'b0, i_cfg.len} > 7'(PATTERN_MAX)) begin
            len_used = 7'(PATTERN_MAX);
        end else begin
            len_used = {1'b0, i_cfg.len};
        end
        len_m1 = 6'(len_used - 7'd1);
    end

    // window byte i lines up with pattern byte len-1-i
    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cmp
        logic [5:0] pj;
        assign pj = len_m1 - 6'(gi);
        assign elem_ok[gi] = (7'(gi) > {1'b0, len_m1}) || pj[5] || i_cfg.wild[pj[4:0]]
                             || (i_cfg.pattern[pj[4:0]] == r_win[gi]);
    end

    assign hit = (7'(r_fill) >= len_used) && (&elem_ok);

    // displacement bytes that arrived before the match completed
    for (genvar gk = 0; gk < wss_pkg::DISP_BYTES; gk++) begin : g_cand
        logic [6:0] dk;
        logic [6:0] diff;
        assign dk = 7'(i_cfg.offset) + 7'(wss_pkg::disp_at(i_cfg.mode)) + 7'(gk);
        assign diff = {1'b0, len_m1} - dk;
        assign avail[gk] = dk <= {1'b0, len_m1};
        assign cand[gk] = avail[gk] ? r_win[diff[WIN_IDX_W-1:0]] : 8'd0;
    end

    always_comb begin
        o_item.data = r_win[0];
        o_item.last = r_last;
        o_item.hit = hit;
        o_item.cand = cand;
        o_item.cand_n = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);
        o_item.mode = i_cfg.mode;
        o_item.offset = i_cfg.offset;
        o_item.len_m1 = len_m1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_fill <= '0;
            r_clr <= 1'b0;
        end else begin
            if (accept) begin
                r_fv <= 1'b1;
                r_fill <= n_fill;
                r_clr <= i_last;
            end else if (o_push) begin
                r_fv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
            r_last <= i_last;
        end
    end

endmodule

`default_nettype wire

[src/wss_fifo.sv]
// ----------------------------------------------------------------------------
// wss_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [PTR_W-1:0]            r_wr_ptr;
    logic [PTR_W-1:0]            r_rd_ptr;
    logic [CNT_W-1:0]            r_count;

    assign o_full = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/wss_back.sv]
// ----------------------------------------------------------------------------
// wss_back
// Stream state: match count, first match start and displacement collection.
// Resolves the target at the end of a stream and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_back #(
    parameter int POSITION_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire wss_pkg::t_item  i_item,
    input  wire logic            i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [1:0]           o_match_count,
    output logic [31:0]          o_match_position,
    output logic [31:0]          o_target_position,
    output logic                 o_ref_complete
);

    localparam int PB = POSITION_BITS;

    logic [PB-1:0] r_pos;
    logic [1:0]    r_seen;
    logic [PB-1:0] r_start;
    logic [31:0]   r_disp;
    logic [2:0]    r_held;

    logic [1:0]    n_seen;
    logic [PB-1:0] n_start;
    logic [31:0]   n_disp;
    logic [2:0]    n_held;

    logic          uses;
    logic          fresh;
    logic [31:0]   fresh_disp;
    logic [6:0]    need;
    logic [PB-1:0] gap;

    logic          r_rv;
    logic [1:0]    r_res_count;
    logic [PB-1:0] r_res_start;
    logic [31:0]   r_res_disp;
    logic          r_res_complete;
    logic [1:0]    r_res_mode;
    logic [5:0]    r_res_offset;

    logic          r_out_valid;
    logic [1:0]    r_out_count;
    logic [31:0]   r_out_position;
    logic [31:0]   r_out_target;
    logic          r_out_complete;

    logic          out_free;
    logic          res_free;
    logic          res_move;
    logic          res_uses;
    logic [PB-1:0] instr;
    logic [PB-1:0] target;

    assign out_free = !r_out_valid || i_ready;
    assign res_free = !r_rv || out_free;
    assign res_move = r_rv && out_free;
    assign o_pop = !i_empty && (!i_item.last || res_free);

    always_comb begin
        uses = wss_pkg::uses_disp(i_item.mode);
        fresh = i_item.hit && (r_seen == 2'd0);
        fresh_disp = '0;
        for (int k = 0; k < wss_pkg::DISP_BYTES; k++) begin
            if (3'(k) < i_item.cand_n) begin
                fresh_disp[8*k +: 8] = i_item.cand[k];
            end
        end
        need = 7'(i_item.offset) + 7'(wss_pkg::disp_at(i_item.mode)) + 7'(r_held);
        gap = r_pos - r_start;

        n_seen = r_seen;
        n_start = r_start;
        n_disp = r_disp;
        n_held = r_held;
        if (i_item.hit) begin
            if (r_seen == 2'd0) begin
                n_start = r_pos - PB'(i_item.len_m1);
                n_disp = '0;
                n_held = '0;
                if (uses) begin
                    n_disp = fresh_disp;
                    n_held = i_item.cand_n;
                end
            end
            if (r_seen != 2'd2) begin
                n_seen = r_seen + 2'd1;
            end
        end
        // take the next displacement byte once the stream reaches it
        if (!fresh && r_seen != 2'd0 && uses && !r_held[2] && gap == PB'(need)) begin
            n_disp = r_disp | (32'(i_item.data) << {r_held[1:0], 3'b000});
            n_held = r_held + 3'd1;
        end
    end

    always_comb begin
        res_uses = wss_pkg::uses_disp(r_res_mode);
        instr = r_res_start + PB'(r_res_offset);
        if (res_uses && r_res_complete) begin
            target = instr + PB'(wss_pkg::instr_len(r_res_mode)) + PB'($signed(r_res_disp));
        end else begin
            target = instr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_seen <= '0;
            r_start <= '0;
            r_disp <= '0;
            r_held <= '0;
            r_rv <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_item.last) begin
                    r_pos <= '0;
                    r_seen <= '0;
                    r_start <= '0;
                    r_disp <= '0;
                    r_held <= '0;
                end else begin
                    r_pos <= r_pos + PB'(1);
                    r_seen <= n_seen;
                    r_start <= n_start;
                    r_disp <= n_disp;
                    r_held <= n_held;
                end
            end
            if (o_pop && i_item.last) begin
                r_rv <= 1'b1;
            end else if (res_move) begin
                r_rv <= 1'b0;
            end
            if (res_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_res_count <= n_seen;
            r_res_start <= n_start;
            r_res_disp <= n_disp;
            r_res_complete <= !uses || n_held[2];
            r_res_mode <= i_item.mode;
            r_res_offset <= i_item.offset;
        end
        if (res_move) begin
            r_out_count <= r_res_count;
            if (r_res_count == 2'd0) begin
                r_out_position <= '0;
                r_out_target <= '0;
                r_out_complete <= 1'b0;
            end else begin
                r_out_position <= 32'(r_res_start);
                r_out_target <= 32'(target);
                r_out_complete <= r_res_complete;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_match_count = r_out_count;
    assign o_match_position = r_out_position;
    assign o_target_position = r_out_target;
    assign o_ref_complete = r_out_complete;

endmodule

`default_nettype wire

[src/wildcard_signature_scanner.sv]
// ----------------------------------------------------------------------------
// wildcard_signature_scanner
// Scans a byte stream for a masked pattern, counts matches and resolves a
// target for the first match, displacement-based in branch and load modes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle if the queue has room; parallel window compare.
// Result path: after the last byte's transaction the result passes the window
//   register, a queue entry, the result stage and the output register.
// Reset: synchronous, active low; clears the configuration to its reset values
//   and all stream state at once, no clearing pass.
`default_nettype none

module wildcard_signature_scanner #(
    parameter int PATTERN_MAX = 32,
    parameter int POSITION_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_match_count,
    output logic [31:0]      o_match_position,
    output logic [31:0]      o_target_position,
    output logic             o_ref_complete
);

    localparam int QUEUE_DEPTH = 4;

    logic [wss_pkg::PATTERN_REGS-1:0][63:0] r_pattern;
    logic [31:0] r_wild;
    logic [5:0]  r_len;
    logic [1:0]  r_mode;
    logic [5:0]  r_offset;

    wss_pkg::t_cfg  cfg;
    wss_pkg::t_item push_item;
    wss_pkg::t_item pop_item;
    logic [$bits(wss_pkg::t_item)-1:0] pop_bits;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_wild <= '0;
            r_len <= 6'd1;
            r_mode <= wss_pkg::MODE_PLAIN;
            r_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wss_pkg::CFG_PATTERN_LOW:      r_pattern[0] <= i_cfg_data;
                wss_pkg::CFG_PATTERN_MID_LOW:  r_pattern[1] <= i_cfg_data;
                wss_pkg::CFG_PATTERN_MID_HIGH: r_pattern[2] <= i_cfg_data;
                wss_pkg::CFG_PATTERN_HIGH:     r_pattern[3] <= i_cfg_data;
                wss_pkg::CFG_WILDCARD_MASK:    r_wild <= i_cfg_data[31:0];
                wss_pkg::CFG_PATTERN_LENGTH:   r_len <= i_cfg_data[5:0];
                wss_pkg::CFG_REF_MODE:         r_mode <= i_cfg_data[1:0];
                wss_pkg::CFG_REF_OFFSET:       r_offset <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.pattern = r_pattern;
        cfg.wild = r_wild;
        cfg.len = r_len;
        cfg.mode = r_mode;
        cfg.offset = r_offset;
    end

    wss_front #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_data_byte),
        .i_last  (i_last_byte),
        .o_push  (push),
        .o_item  (push_item),
        .i_full  (full)
    );

    wss_fifo #(
        .WIDTH($bits(wss_pkg::t_item)),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_bits),
        .o_empty (empty)
    );

    assign pop_item = wss_pkg::t_item'(pop_bits);

    wss_back #(
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (pop_item),
        .i_empty           (empty),
        .o_pop             (pop),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_match_count     (o_match_count),
        .o_match_position  (o_match_position),
        .o_target_position (o_target_position),
        .o_ref_complete    (o_ref_complete)
    );

endmodule

`default_nettype wire

[src/wss_checker.sv]
// ----------------------------------------------------------------------------
// wss_checker
// Port-level checks of the scanner's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_match_count,
    input wire logic [31:0] o_match_position,
    input wire logic [31:0] o_target_position,
    input wire logic        o_ref_complete
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_match_count)
            && $stable(o_match_position) && $stable(o_target_position)
            && $stable(o_ref_complete))
        else $error("result changed while stalled");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_match_count != 2'd3)
        else $error("match count above saturation");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_match_count == 2'd0 |-> o_match_position == 32'd0
            && o_target_position == 32'd0 && !o_ref_complete)
        else $error("no-match result carries nonzero fields");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind wildcard_signature_scanner wss_checker u_wss_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_match_count     (o_match_count),
    .o_match_position  (o_match_position),
    .o_target_position (o_target_position),
    .o_ref_complete    (o_ref_complete)
);

`default_nettype wire
